[src/bilinear_remap_sampler_unit_assert.svh]
// assertion macros for the bilinear remap sampler
`ifndef BILINEAR_REMAP_SAMPLER_UNIT_ASSERT_SVH
`define BILINEAR_REMAP_SAMPLER_UNIT_ASSERT_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define BRS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on every rising clock edge outside reset
`define BRS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/brs_pkg.sv]
// shared constants, codes and types of the bilinear remap sampler
`timescale 1ns / 1ps

package brs_pkg;

   // fixed-point format of the remap coordinates
   localparam int FRAC_BITS = 8;
   localparam int COORD_W   = 18;
   localparam int INT_W     = COORD_W - FRAC_BITS;

   // frame geometry
   localparam int DIM_W      = 11;
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int CMP_W      = (INT_W >= DIM_W) ? INT_W + 1 : DIM_W;

   // frame store, split into an even and an odd bank
   localparam int ADDR_W     = 20;
   localparam int PIX_W      = 16;
   localparam int BANK_AW    = ADDR_W - 1;
   localparam int BANK_DEPTH = 1 << BANK_AW;

   // blend arithmetic
   localparam int ONE_W  = FRAC_BITS + 1;
   localparam int WGT_W  = 2 * FRAC_BITS + 1;
   localparam int PROD_W = PIX_W + WGT_W;
   localparam int ACC_W  = PROD_W + 2;

   // configuration registers
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_SRC_HEIGHT = CSR_IDX_W'(1);
   localparam logic [DIM_W-1:0]     WIDTH_RESET    = DIM_W'(640);
   localparam logic [DIM_W-1:0]     HEIGHT_RESET   = DIM_W'(480);

   // request type codes
   localparam logic REQ_STORE  = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_STORE,
      KIND_BLEND,
      KIND_ZERO,
      KIND_OOR
   } brs_kind_type;

   // one classified item
   typedef struct packed {
      brs_kind_type            kind;
      logic [ADDR_W-1:0]       addr;
      logic [PIX_W-1:0]        value;
      logic [INT_W-1:0]        xi;
      logic [INT_W-1:0]        yi;
      logic [FRAC_BITS-1:0]    fx;
      logic [FRAC_BITS-1:0]    fy;
      logic [DIM_W-1:0]        width;
   } brs_op_type;

   // queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } brs_qstat_type;

endpackage

[src/brs_ram.sv]
// generic single-write dual-read ram with registered read data
`timescale 1ns / 1ps

module brs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // two read ports, data held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

[src/brs_queue.sv]
// short item queue between the front and the back
`timescale 1ns / 1ps

module brs_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  brs_pkg::brs_op_type   push_op,
   input  logic                  pop,
   output brs_pkg::brs_op_type   head_op,
   output brs_pkg::brs_qstat_type qstat
);

   brs_pkg::brs_op_type             slot_ff [brs_pkg::QUEUE_DEPTH];
   logic [brs_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [brs_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [brs_pkg::QCNT_W-1:0]      count_ff, count_in;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == brs_pkg::QPTR_W'(brs_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + brs_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == brs_pkg::QPTR_W'(brs_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + brs_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + brs_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - brs_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // item storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

   assign head_op     = slot_ff[rd_ptr_ff];
   assign qstat.full  = (count_ff == brs_pkg::QCNT_W'(brs_pkg::QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);

endmodule

[src/brs_front.sv]
// front end: configuration registers, item intake and classification
`timescale 1ns / 1ps

module brs_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_type,
   input  logic [brs_pkg::ADDR_W-1:0]       req_pixel_addr,
   input  logic [brs_pkg::PIX_W-1:0]        req_pixel_value,
   input  logic [brs_pkg::COORD_W-1:0]      req_map_x,
   input  logic [brs_pkg::COORD_W-1:0]      req_map_y,
   input  logic                             req_map_valid,
   input  logic                             csr_wr_en,
   input  logic [brs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [brs_pkg::DIM_W-1:0]        csr_wr_data,
   input  brs_pkg::brs_qstat_type           qstat,
   output logic                             push,
   output brs_pkg::brs_op_type              push_op
);

   logic [brs_pkg::DIM_W-1:0]     width_ff, width_in;
   logic [brs_pkg::DIM_W-1:0]     height_ff, height_in;
   logic [brs_pkg::DIM_W-1:0]     w_eff, h_eff;
   logic [brs_pkg::INT_W-1:0]     xi, yi;
   logic [brs_pkg::CMP_W-1:0]     xi_p1, yi_p1;
   logic                          oor;

   // configuration writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            brs_pkg::REG_SRC_WIDTH:  width_in  = csr_wr_data;
            brs_pkg::REG_SRC_HEIGHT: height_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= brs_pkg::WIDTH_RESET;
         height_ff <= brs_pkg::HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // frame size saturated to the supported maximum
   assign w_eff = (width_ff > brs_pkg::DIM_W'(brs_pkg::MAX_WIDTH)) ?
                  brs_pkg::DIM_W'(brs_pkg::MAX_WIDTH) : width_ff;
   assign h_eff = (height_ff > brs_pkg::DIM_W'(brs_pkg::MAX_HEIGHT)) ?
                  brs_pkg::DIM_W'(brs_pkg::MAX_HEIGHT) : height_ff;

   // integer part of the coordinates and the 2x2 bounds check
   assign xi    = req_map_x[brs_pkg::COORD_W-1:brs_pkg::FRAC_BITS];
   assign yi    = req_map_y[brs_pkg::COORD_W-1:brs_pkg::FRAC_BITS];
   assign xi_p1 = brs_pkg::CMP_W'(xi) + brs_pkg::CMP_W'(1);
   assign yi_p1 = brs_pkg::CMP_W'(yi) + brs_pkg::CMP_W'(1);
   assign oor   = (xi_p1 >= brs_pkg::CMP_W'(w_eff)) || (yi_p1 >= brs_pkg::CMP_W'(h_eff));

   // classify the item
   always_comb begin
      push_op.addr  = req_pixel_addr;
      push_op.value = req_pixel_value;
      push_op.xi    = xi;
      push_op.yi    = yi;
      push_op.fx    = req_map_x[brs_pkg::FRAC_BITS-1:0];
      push_op.fy    = req_map_y[brs_pkg::FRAC_BITS-1:0];
      push_op.width = w_eff;
      priority if (req_type == brs_pkg::REQ_STORE) begin
         push_op.kind = brs_pkg::KIND_STORE;
      end else if (!req_map_valid) begin
         push_op.kind = brs_pkg::KIND_ZERO;
      end else if (oor) begin
         push_op.kind = brs_pkg::KIND_OOR;
      end else begin
         push_op.kind = brs_pkg::KIND_BLEND;
      end
   end

   // intake handshake, held off only by a full queue
   assign req_stall = qstat.full;
   assign push      = req_valid && !qstat.full;

endmodule

[src/brs_back.sv]
// back end: address build, banked frame store access and bilinear blend
`timescale 1ns / 1ps

module brs_back (
   input  logic                          clock,
   input  logic                          reset,
   input  brs_pkg::brs_qstat_type        qstat,
   input  brs_pkg::brs_op_type           head_op,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [brs_pkg::PIX_W-1:0]     rsp_sample_value,
   output logic                          rsp_out_of_range
);

   logic                              en;

   // stage 1: item taken from the queue
   logic                              s1_valid_ff;
   brs_pkg::brs_op_type               s1_op_ff;
   logic [brs_pkg::INT_W+brs_pkg::DIM_W-1:0] row_off;
   logic [brs_pkg::ADDR_W-1:0]        base_in;

   // stage 2: linear base address
   logic                              s2_valid_ff;
   brs_pkg::brs_kind_type             s2_kind_ff;
   logic [brs_pkg::ADDR_W-1:0]        s2_addr_ff;
   logic [brs_pkg::PIX_W-1:0]         s2_value_ff;
   logic [brs_pkg::FRAC_BITS-1:0]     s2_fx_ff, s2_fy_ff;
   logic [brs_pkg::DIM_W-1:0]         s2_width_ff;
   logic [brs_pkg::ADDR_W-1:0]        top_a, top_a1, bot_a, bot_a1;
   logic [brs_pkg::ONE_W-1:0]         ifx, ify, fx_w, fy_w;
   logic                              wr_store;

   // stage 3: frame data and weights
   logic                              s3_valid_ff;
   brs_pkg::brs_kind_type             s3_kind_ff;
   logic                              s3_swap_top_ff, s3_swap_bot_ff;
   logic [brs_pkg::WGT_W-1:0]         s3_w_tl_ff, s3_w_tr_ff, s3_w_bl_ff, s3_w_br_ff;
   logic [brs_pkg::PIX_W-1:0]         even_a, even_b, odd_a, odd_b;
   logic [brs_pkg::PIX_W-1:0]         pix_tl, pix_tr, pix_bl, pix_br;

   // stage 4: weighted products
   logic                              s4_valid_ff;
   brs_pkg::brs_kind_type             s4_kind_ff;
   logic [brs_pkg::PROD_W-1:0]        s4_p_tl_ff, s4_p_tr_ff, s4_p_bl_ff, s4_p_br_ff;
   logic [brs_pkg::ACC_W-1:0]         acc;

   // output register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [brs_pkg::PIX_W-1:0]         rsp_value_ff, rsp_value_in;
   logic                              rsp_oor_ff, rsp_oor_in;

   // the whole back pipeline moves unless a finished result is blocked
   assign en  = !(rsp_valid_ff && rsp_stall);
   assign pop = en && !qstat.empty;

   // stage 1 logic: base = row * width + col
   assign row_off = (brs_pkg::INT_W + brs_pkg::DIM_W)'(s1_op_ff.yi) *
                    (brs_pkg::INT_W + brs_pkg::DIM_W)'(s1_op_ff.width);
   assign base_in = (s1_op_ff.kind == brs_pkg::KIND_STORE) ? s1_op_ff.addr :
                    brs_pkg::ADDR_W'(row_off) + brs_pkg::ADDR_W'(s1_op_ff.xi);

   // stage 2 logic: neighbour addresses, wrapping in the store
   assign top_a  = s2_addr_ff;
   assign top_a1 = s2_addr_ff + brs_pkg::ADDR_W'(1);
   assign bot_a  = s2_addr_ff + brs_pkg::ADDR_W'(s2_width_ff);
   assign bot_a1 = bot_a + brs_pkg::ADDR_W'(1);

   // stage 2 logic: blend weights from the fraction parts
   assign fx_w = brs_pkg::ONE_W'(s2_fx_ff);
   assign fy_w = brs_pkg::ONE_W'(s2_fy_ff);
   assign ifx  = brs_pkg::ONE_W'(1 << brs_pkg::FRAC_BITS) - fx_w;
   assign ify  = brs_pkg::ONE_W'(1 << brs_pkg::FRAC_BITS) - fy_w;

   assign wr_store = en && s2_valid_ff && (s2_kind_ff == brs_pkg::KIND_STORE);

   // even bank holds even linear addresses; each pair of neighbours hits both banks
   brs_ram #(
      .WIDTH (brs_pkg::PIX_W),
      .DEPTH (brs_pkg::BANK_DEPTH)
   ) u_even_bank (
      .clock     (clock),
      .wr_en     (wr_store && !s2_addr_ff[0]),
      .wr_addr   (s2_addr_ff[brs_pkg::ADDR_W-1:1]),
      .wr_data   (s2_value_ff),
      .rd_en     (en),
      .rd_addr_a (top_a1[brs_pkg::ADDR_W-1:1]),
      .rd_addr_b (bot_a1[brs_pkg::ADDR_W-1:1]),
      .rd_data_a (even_a),
      .rd_data_b (even_b)
   );

   brs_ram #(
      .WIDTH (brs_pkg::PIX_W),
      .DEPTH (brs_pkg::BANK_DEPTH)
   ) u_odd_bank (
      .clock     (clock),
      .wr_en     (wr_store && s2_addr_ff[0]),
      .wr_addr   (s2_addr_ff[brs_pkg::ADDR_W-1:1]),
      .wr_data   (s2_value_ff),
      .rd_en     (en),
      .rd_addr_a (top_a[brs_pkg::ADDR_W-1:1]),
      .rd_addr_b (bot_a[brs_pkg::ADDR_W-1:1]),
      .rd_data_a (odd_a),
      .rd_data_b (odd_b)
   );

   // stage 3 logic: put bank outputs back in left/right order
   assign pix_tl = s3_swap_top_ff ? odd_a  : even_a;
   assign pix_tr = s3_swap_top_ff ? even_a : odd_a;
   assign pix_bl = s3_swap_bot_ff ? odd_b  : even_b;
   assign pix_br = s3_swap_bot_ff ? even_b : odd_b;

   // stage 4 logic: sum of products, truncated to 8.8
   assign acc = brs_pkg::ACC_W'(s4_p_tl_ff) + brs_pkg::ACC_W'(s4_p_tr_ff) +
                brs_pkg::ACC_W'(s4_p_bl_ff) + brs_pkg::ACC_W'(s4_p_br_ff);

   always_comb begin
      rsp_valid_in = s4_valid_ff && (s4_kind_ff != brs_pkg::KIND_STORE);
      unique case (s4_kind_ff)
         brs_pkg::KIND_BLEND: begin
            rsp_value_in = acc[2*brs_pkg::FRAC_BITS +: brs_pkg::PIX_W];
            rsp_oor_in   = 1'b0;
         end
         brs_pkg::KIND_OOR: begin
            rsp_value_in = '0;
            rsp_oor_in   = 1'b1;
         end
         default: begin
            rsp_value_in = '0;
            rsp_oor_in   = 1'b0;
         end
      endcase
   end

   // stage valid bits and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff  <= !qstat.empty;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (en) begin
         s1_op_ff       <= head_op;

         s2_kind_ff     <= s1_op_ff.kind;
         s2_addr_ff     <= base_in;
         s2_value_ff    <= s1_op_ff.value;
         s2_fx_ff       <= s1_op_ff.fx;
         s2_fy_ff       <= s1_op_ff.fy;
         s2_width_ff    <= s1_op_ff.width;

         s3_kind_ff     <= s2_kind_ff;
         s3_swap_top_ff <= top_a[0];
         s3_swap_bot_ff <= bot_a[0];
         s3_w_tl_ff     <= brs_pkg::WGT_W'(ifx)  * brs_pkg::WGT_W'(ify);
         s3_w_tr_ff     <= brs_pkg::WGT_W'(fx_w) * brs_pkg::WGT_W'(ify);
         s3_w_bl_ff     <= brs_pkg::WGT_W'(ifx)  * brs_pkg::WGT_W'(fy_w);
         s3_w_br_ff     <= brs_pkg::WGT_W'(fx_w) * brs_pkg::WGT_W'(fy_w);

         s4_kind_ff     <= s3_kind_ff;
         s4_p_tl_ff     <= brs_pkg::PROD_W'(pix_tl) * brs_pkg::PROD_W'(s3_w_tl_ff);
         s4_p_tr_ff     <= brs_pkg::PROD_W'(pix_tr) * brs_pkg::PROD_W'(s3_w_tr_ff);
         s4_p_bl_ff     <= brs_pkg::PROD_W'(pix_bl) * brs_pkg::PROD_W'(s3_w_bl_ff);
         s4_p_br_ff     <= brs_pkg::PROD_W'(pix_br) * brs_pkg::PROD_W'(s3_w_br_ff);

         rsp_value_ff   <= rsp_value_in;
         rsp_oor_ff     <= rsp_oor_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_value = rsp_value_ff;
   assign rsp_out_of_range = rsp_oor_ff;

endmodule

[src/bilinear_remap_sampler_unit.sv]
// top level of the bilinear remap sampler
//
//  port group | direction | handshake           | carries
//  req_*      | in        | req_valid/req_stall | store pixel or remap sample item
//  rsp_*      | out       | rsp_valid/rsp_stall | blended 8.8 value and range flag
//  csr_*      | in        | csr_wr_en           | src_width (0), src_height (1)
//
// one item per cycle while no finished result is held by rsp_stall; a sample's result passes
// through the queue slot, base multiply, banked read, product and sum registers
// a store is written to the frame banks in stage 2, where later samples read, so they see it
// reset clears control only; the frame store is not cleared and reads of unwritten pixels are
// undefined
// rsp_stall freezes the back pipeline while a result waits; the four-item queue keeps taking items until full
`timescale 1ns / 1ps
`include "bilinear_remap_sampler_unit_assert.svh"

module bilinear_remap_sampler_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_type,
   input  logic [brs_pkg::ADDR_W-1:0]       req_pixel_addr,
   input  logic [brs_pkg::PIX_W-1:0]        req_pixel_value,
   input  logic [brs_pkg::COORD_W-1:0]      req_map_x,
   input  logic [brs_pkg::COORD_W-1:0]      req_map_y,
   input  logic                             req_map_valid,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [brs_pkg::PIX_W-1:0]        rsp_sample_value,
   output logic                             rsp_out_of_range,
   input  logic                             csr_wr_en,
   input  logic [brs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [brs_pkg::DIM_W-1:0]        csr_wr_data
);

   brs_pkg::brs_qstat_type qstat;
   brs_pkg::brs_op_type    push_op;
   brs_pkg::brs_op_type    head_op;
   logic                   push;
   logic                   pop;

   // intake and classification
   brs_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_pixel_addr  (req_pixel_addr),
      .req_pixel_value (req_pixel_value),
      .req_map_x       (req_map_x),
      .req_map_y       (req_map_y),
      .req_map_valid   (req_map_valid),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .qstat           (qstat),
      .push            (push),
      .push_op         (push_op)
   );

   // decoupling queue
   brs_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .pop     (pop),
      .head_op (head_op),
      .qstat   (qstat)
   );

   // memory access and blend
   brs_back u_back (
      .clock            (clock),
      .reset            (reset),
      .qstat            (qstat),
      .head_op          (head_op),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample_value (rsp_sample_value),
      .rsp_out_of_range (rsp_out_of_range)
   );

   // checks across the front, queue and back
   `BRS_ASSERT_NOW(a_pop_has_item, pop, !qstat.empty, "back took an item from an empty queue")
   `BRS_ASSERT_NOW(a_no_pop_blocked, rsp_valid && rsp_stall, !pop, "back advanced under a blocked result")
   `BRS_ASSERT_NEXT(a_push_lands, req_valid && !req_stall && !pop, !qstat.empty, "taken item missing from queue")

endmodule
